// ===== src/fbg_frame_wavelength_parser_core_defines.svh =====
// ----------------------------------------------------------------------------
// fbg frame wavelength parser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FBG_FRAME_WAVELENGTH_PARSER_CORE_DEFINES_SVH
`define FBG_FRAME_WAVELENGTH_PARSER_CORE_DEFINES_SVH

// antecedent and consequent in the same cycle
`define FWP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fwp check failed");

// consequent in the cycle after the antecedent
`define FWP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fwp check failed");

`endif

// ===== src/fwp_pkg.sv =====
// ----------------------------------------------------------------------------
// fwp_pkg
// constants shared by the fbg frame wavelength parser and its checker
// ----------------------------------------------------------------------------
`default_nettype none

package fwp_pkg;

  localparam int POS_W = 10;
  localparam int OFF_W = 6;
  localparam int CH_W  = 4;
  localparam int WL_W  = 21;
  localparam int IDX_W = 5;

  localparam logic [POS_W-1:0] FIRST_BLOCK = 10'd3;
  localparam logic [POS_W-1:0] LAST_BYTE   = 10'd993;
  localparam logic [POS_W-1:0] POS_MAX     = 10'd1023;
  localparam logic [POS_W-1:0] POS_HDR0    = 10'd0;
  localparam logic [POS_W-1:0] POS_HDR1    = 10'd1;
  localparam logic [POS_W-1:0] POS_PRE     = 10'd2;
  localparam logic [OFF_W-1:0] OFF_LAST    = 6'd61;

  localparam logic [7:0] HDR_NULL       = 8'h00;
  localparam logic [7:0] HDR_ASCII_ZERO = 8'h30;
  localparam logic [7:0] HDR_ASCII_E    = 8'h45;
  localparam logic [7:0] HDR_BAD_FIRST  = 8'h01;
  localparam logic [7:0] HDR_BAD_SECOND = 8'h02;
  localparam logic [7:0] HDR_LOWER_BANK = 8'd12;

  localparam logic [IDX_W-1:0] PAIRS_PER_CH = 5'd30;
  localparam int               POINTS_KEPT_DEFAULT = 20;

  localparam logic [WL_W-1:0] BASE_RESET = 21'd1520000;
  localparam logic [WL_W-1:0] WL_MAX     = 21'h1FFFFF;

endpackage

`default_nettype wire

// ===== src/fbg_frame_wavelength_parser_core.sv =====
// ----------------------------------------------------------------------------
// fbg frame wavelength parser core
// Takes one datagram byte per item and emits one wavelength result, in pm,
// on the high byte of each kept point of each channel block. Every item is
// handled in the cycle it is accepted, so the block takes one byte per cycle;
// results land in an output register backed by a one-entry skid register, and
// input stall rises only while both hold a result. Channel and offset within
// a block come from counters stepped per byte, not from the byte position.
// Frames with a bad header are dropped until the next frame start.
// ----------------------------------------------------------------------------
`default_nettype none

module fbg_frame_wavelength_parser_core #(
  parameter int POINTS_KEPT = fwp_pkg::POINTS_KEPT_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     frame_start,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [4:0]                    channel,
  output logic [fwp_pkg::IDX_W-1:0]     point_index,
  output logic [fwp_pkg::WL_W-1:0]      wavelength_pm,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [fwp_pkg::WL_W-1:0] base_wavelength_pm
);

  logic [fwp_pkg::WL_W-1:0]  base_pm;
  logic [fwp_pkg::POS_W-1:0] byte_position;
  logic [7:0]                first_header_byte;
  logic                      upper_bank;
  logic                      frame_dropped;
  logic [7:0]                point_count;
  logic [7:0]                held_low_byte;
  logic [fwp_pkg::OFF_W-1:0] offset;
  logic [fwp_pkg::CH_W-1:0]  chan;

  logic                      skid_valid;
  logic [4:0]                skid_channel;
  logic [fwp_pkg::IDX_W-1:0] skid_index;
  logic [fwp_pkg::WL_W-1:0]  skid_wl;

  logic                      in_fire;
  logic                      out_fire;
  logic [fwp_pkg::POS_W-1:0] pos_eff;
  logic                      active;
  logic                      in_block;
  logic [fwp_pkg::IDX_W-1:0] pair_idx;
  logic                      emit;
  logic                      res_valid;
  logic [fwp_pkg::WL_W:0]    wl_sum;
  logic [fwp_pkg::WL_W-1:0]  res_wl;
  logic [4:0]                res_channel;

  logic [fwp_pkg::POS_W-1:0] byte_position_next;
  logic [7:0]                first_header_byte_next;
  logic                      upper_bank_next;
  logic                      frame_dropped_next;
  logic [7:0]                point_count_next;
  logic [7:0]                held_low_byte_next;
  logic [fwp_pkg::OFF_W-1:0] offset_next;
  logic [fwp_pkg::CH_W-1:0]  chan_next;

  function automatic logic [fwp_pkg::IDX_W-1:0] pair_index_of(
    input logic [fwp_pkg::OFF_W-1:0] off
  );
    logic [fwp_pkg::OFF_W-1:0] half;
    half = (off >> 1) - 6'd1;
    return half[fwp_pkg::IDX_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  assign pos_eff  = frame_start ? fwp_pkg::POS_HDR0 : byte_position;
  assign active   = frame_start || !frame_dropped;
  assign in_block = (pos_eff >= fwp_pkg::FIRST_BLOCK) && (pos_eff <= fwp_pkg::LAST_BYTE);
  assign pair_idx = pair_index_of(offset);

  assign emit = active && in_block && (offset != '0) && !offset[0]
                && (pair_idx < POINTS_KEPT[fwp_pkg::IDX_W-1:0]);
  assign res_valid = in_fire && emit;

  // pair wavelength, zero past the signed point count, saturating at WL_MAX
  always_comb begin
    wl_sum = {1'b0, base_pm} + {6'd0, data_byte, held_low_byte};
    if (point_count[7] || ({2'b00, pair_idx} >= point_count[6:0])) begin
      res_wl = '0;
    end else if (wl_sum[fwp_pkg::WL_W]) begin
      res_wl = fwp_pkg::WL_MAX;
    end else begin
      res_wl = wl_sum[fwp_pkg::WL_W-1:0];
    end
    res_channel = {upper_bank, chan};
  end

  always_comb begin
    byte_position_next     = (pos_eff < fwp_pkg::POS_MAX) ? pos_eff + 10'd1 : pos_eff;
    first_header_byte_next = first_header_byte;
    upper_bank_next        = upper_bank;
    frame_dropped_next     = frame_start ? 1'b0 : frame_dropped;
    point_count_next       = point_count;
    held_low_byte_next     = held_low_byte;
    if (pos_eff == fwp_pkg::POS_PRE) begin
      offset_next = '0;
      chan_next   = '0;
    end else if (offset == fwp_pkg::OFF_LAST) begin
      offset_next = '0;
      chan_next   = chan + 4'd1;
    end else begin
      offset_next = offset + 6'd1;
      chan_next   = chan;
    end
    if (active) begin
      if (pos_eff == fwp_pkg::POS_HDR0) begin
        first_header_byte_next = data_byte;
        if (data_byte == fwp_pkg::HDR_NULL || data_byte == fwp_pkg::HDR_ASCII_ZERO) begin
          frame_dropped_next = 1'b1;
        end
      end else if (pos_eff == fwp_pkg::POS_HDR1) begin
        if (data_byte == fwp_pkg::HDR_ASCII_E
            || (first_header_byte == fwp_pkg::HDR_BAD_FIRST
                && data_byte == fwp_pkg::HDR_BAD_SECOND)) begin
          frame_dropped_next = 1'b1;
        end
        upper_bank_next = (data_byte != fwp_pkg::HDR_LOWER_BANK);
      end else if (in_block) begin
        if (offset == '0) begin
          point_count_next = data_byte;
        end else if (offset[0]) begin
          held_low_byte_next = data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_pm           <= fwp_pkg::BASE_RESET;
      byte_position     <= '0;
      first_header_byte <= '0;
      upper_bank        <= 1'b0;
      frame_dropped     <= 1'b1;
      point_count       <= '0;
      held_low_byte     <= '0;
      offset            <= '0;
      chan              <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base_pm <= base_wavelength_pm;
      end
      if (in_fire) begin
        byte_position     <= byte_position_next;
        first_header_byte <= first_header_byte_next;
        upper_bank        <= upper_bank_next;
        frame_dropped     <= frame_dropped_next;
        point_count       <= point_count_next;
        held_low_byte     <= held_low_byte_next;
        offset            <= offset_next;
        chan              <= chan_next;
      end
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        channel       <= skid_channel;
        point_index   <= skid_index;
        wavelength_pm <= skid_wl;
      end
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        channel       <= res_channel;
        point_index   <= pair_idx;
        wavelength_pm <= res_wl;
      end else begin
        skid_channel <= res_channel;
        skid_index   <= pair_idx;
        skid_wl      <= res_wl;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/fwp_checker.sv =====
// ----------------------------------------------------------------------------
// fwp_checker
// port level checks for the fbg frame wavelength parser core
// ----------------------------------------------------------------------------
`default_nettype none

`include "fbg_frame_wavelength_parser_core_defines.svh"

module fwp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [4:0]                  channel,
  input wire logic [fwp_pkg::IDX_W-1:0]   point_index,
  input wire logic [fwp_pkg::WL_W-1:0]    wavelength_pm
);

  `FWP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(channel) && $stable(point_index) && $stable(wavelength_pm))
  `FWP_ASSERT_SAME(a_stall_needs_result, in_stall, out_valid)
  `FWP_ASSERT_SAME(a_result_from_item, $rose(out_valid), $past(in_valid && !in_stall))
  `FWP_ASSERT_SAME(a_index_range, out_valid, point_index < fwp_pkg::PAIRS_PER_CH)

endmodule

bind fbg_frame_wavelength_parser_core fwp_checker u_fwp_checker (.*);

`default_nettype wire
